// File: design/kvit_pkg.sv
// ----------------------------------------------------------------------------
// kvit_pkg: shared types and constants of the key/value index table
// Field widths, action and status codes, the entry and match records handed
// between the cells and the match tree, and the controller state type.
// ----------------------------------------------------------------------------
package kvit_pkg;

  localparam int KEY_W   = 32;
  localparam int POS_W   = 32;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = 8;

  // The match tree merges sixteen nodes per registered level.
  localparam int TREE_RADIX_LOG = 4;
  localparam int TREE_RADIX     = 1 << TREE_RADIX_LOG;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  // One stored pair. A duplicate entry repeats a key that an older live
  // entry already holds and therefore never answers a lookup.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
    logic             dup;
  } entry_t;

  // Match report of one cell; position is zero when there is no hit.
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
  } match_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // Number of registered levels needed to merge the given number of leaves.
  function automatic int tree_levels(input int leaves);
    return ($clog2(leaves) + TREE_RADIX_LOG - 1) / TREE_RADIX_LOG;
  endfunction

endpackage

// File: design/kvit_cell.sv
// ----------------------------------------------------------------------------
// kvit_cell: one storage cell of the index table chain
// Holds one entry, passes it to the next cell when the chain shifts, and
// compares its key against the broadcast request key.
// ----------------------------------------------------------------------------
module kvit_cell
  import kvit_pkg::*;
(
  input  logic             clk,
  input  logic             shift_en,
  input  logic             enable,
  input  logic [KEY_W-1:0] req_key,
  input  entry_t           left_entry,
  output entry_t           entry,
  output match_t           match
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= left_entry;
    end
  end

  // Only live, non-duplicate entries may answer.
  always_comb begin
    match.hit      = enable && !entry.dup && (entry.key == req_key);
    match.position = match.hit ? entry.position : '0;
  end

endmodule

// File: design/kvit_match_tree.sv
// ----------------------------------------------------------------------------
// kvit_match_tree: registered OR tree over the cell match reports
// Merges sixteen reports per level; at most one report is ever a hit, so an
// OR gives both the hit flag and the matching position.
// ----------------------------------------------------------------------------
module kvit_match_tree
  import kvit_pkg::*;
#(
  parameter int LEAVES = 128
) (
  input  logic   clk,
  input  match_t leaf [LEAVES],
  output match_t root
);

  localparam int LEVELS = tree_levels(LEAVES);

  match_t node_q [LEVELS][LEAVES];

  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
    localparam int SRC_N = (LEAVES + (1 << (TREE_RADIX_LOG * lv)) - 1)
                           >> (TREE_RADIX_LOG * lv);
    localparam int DST_N = (SRC_N + TREE_RADIX - 1) / TREE_RADIX;

    for (genvar j = 0; j < DST_N; j++) begin : g_node
      localparam int LO  = j * TREE_RADIX;
      localparam int CNT = (SRC_N - LO < TREE_RADIX) ? (SRC_N - LO) : TREE_RADIX;

      match_t acc;

      if (lv == 0) begin : g_first
        always_comb begin
          acc = '0;
          for (int m = 0; m < CNT; m++) begin
            acc = acc | leaf[LO + m];
          end
        end
      end else begin : g_upper
        always_comb begin
          acc = '0;
          for (int m = 0; m < CNT; m++) begin
            acc = acc | node_q[lv-1][LO + m];
          end
        end
      end

      always_ff @(posedge clk) begin
        node_q[lv][j] <= acc;
      end
    end
  end

  assign root = node_q[LEVELS-1][0];

endmodule

// File: design/key_value_index_table.sv
// A result is registered once its request has been captured, has passed the
// LEVELS = ceil(log2(CAPACITY) / 4) registered levels of the match tree (2 at
// CAPACITY = 128) and has left the finish state into the output register.
// The table takes a new request only while idle, after the current result
// has retired, and out_stall can hold that retirement back.
// Reset: synchronous, clears the controller, the entry count and the output
// valid flag; the cell contents stay undefined until they are written.
// ----------------------------------------------------------------------------
// key_value_index_table: index table mapping record keys to positions
// A chain of CAPACITY cells holds the entries, newest in cell 0. Every live
// cell compares its key against the request in parallel and a registered OR
// tree gathers the single possible match.
// ----------------------------------------------------------------------------
module key_value_index_table
  import kvit_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  // Request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ACT_W-1:0]   action,
  input  logic [KEY_W-1:0]   key,
  input  logic [POS_W-1:0]   position,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [POS_W-1:0]   found_position,
  output logic [ENTRY_W-1:0] entry_count
);

  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LVL_W  = $clog2(LEVELS + 1);

  // Controller state and the request being worked on.
  state_t             state;
  state_t             state_next;
  logic [LVL_W-1:0]   lvl_cnt;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [ACT_W-1:0]   act_q;
  logic [KEY_W-1:0]   key_q;
  logic [POS_W-1:0]   pos_q;

  logic               in_go;
  logic               fin_go;
  logic               shift_en;
  logic [STAT_W-1:0]  status_next;
  logic [POS_W-1:0]   found_next;

  entry_t             new_entry;
  entry_t             cell_entry [CAPACITY];
  match_t             cell_match [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;
  match_t             root;

  // --------------------------------------------------------------------------
  // Cell chain. An add shifts every entry one cell along and enters the new
  // pair at cell 0, so the live entries always sit in cells below the count.
  // The entry that falls off the far end is never live when a shift happens,
  // because a full table refuses the add.
  // --------------------------------------------------------------------------

  // A repeated key is stored as a duplicate, so the earliest live entry of
  // that key stays the only one that can answer a lookup.
  always_comb begin
    new_entry.key      = key_q;
    new_entry.position = pos_q;
    new_entry.dup      = root.hit;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left;

    if (i == 0) begin : g_head
      assign left = new_entry;
    end else begin : g_body
      assign left = cell_entry[i-1];
    end

    kvit_cell u_cell (
      .clk        (clk),
      .shift_en   (shift_en),
      .enable     (count > CNT_W'(i)),
      .req_key    (key_q),
      .left_entry (left),
      .entry      (cell_entry[i]),
      .match      (cell_match[i])
    );

    assign hit_vec[i] = cell_match[i].hit;
  end

  // The tree sees the cells of the current request throughout the search,
  // since neither the cells nor the request change until the result retires.
  kvit_match_tree #(
    .LEAVES (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_match),
    .root (root)
  );

  // --------------------------------------------------------------------------
  // Controller: accept a request, stay in the search state while the LEVELS
  // tree levels fill, then retire the result into the output register as soon as that is free.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_go) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lvl_cnt == LVL_W'(LEVELS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Handshake, result and count update for the request in hand.
  always_comb begin
    in_stall    = (state != ST_IDLE);
    in_go       = in_valid && !in_stall;
    fin_go      = (state == ST_FINISH) && (!out_valid || !out_stall);
    shift_en    = 1'b0;
    status_next = STAT_OK;
    found_next  = '0;
    count_next  = count;
    case (act_q)
      ACT_ADD: begin
        if (count == CNT_W'(CAPACITY)) begin
          status_next = STAT_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          shift_en   = fin_go;
        end
      end
      ACT_LOOKUP: begin
        if (root.hit) begin
          found_next = root.position;
        end else begin
          status_next = STAT_MISSING;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // The spare action code does nothing and reports success.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lvl_cnt   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SEARCH) begin
        lvl_cnt <= lvl_cnt + LVL_W'(1);
      end else begin
        lvl_cnt <= '0;
      end
      if (fin_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_go) begin
      act_q <= action;
      key_q <= key;
      pos_q <= position;
    end
    if (fin_go) begin
      status         <= status_next;
      found_position <= found_next;
      entry_count    <= ENTRY_W'(count_next);
    end
  end

`ifndef ASSERT_OFF
  // The count never runs past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Duplicate marking leaves at most one live cell that can answer.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell matches the request key");

  // The count only moves when a result retires.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FINISH) |=> $stable(count))
    else $error("entry count changed outside result retirement");

  // A new result appears only from the retirement state.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result raised without a finished request");
`endif

endmodule
